FILE: src/vltc_pkg.sv
// Package for the voxel leaf classifier: grid sizes, codes, shared types and
// the leaf template / rotation tables. No dependencies.
package vltc_pkg;

  localparam int GRID_X         = 64;
  localparam int GRID_Y         = 64;
  localparam int GRID_Z         = 64;
  localparam int ROTATION_COUNT = 24;
  localparam int TEMPLATE_COUNT = 9;
  localparam int TEMPLATE_MAX   = 3;

  localparam int COORD_W = 6;
  localparam int ADDR_W  = $clog2(GRID_X * GRID_Y);
  localparam int ZIDX_W  = $clog2(GRID_Z);
  localparam int NBH_W   = 27;
  localparam int CNT_W   = 5;
  localparam int TMPL_W  = 4;
  localparam int ROT_W   = 5;

  // Operation codes
  localparam logic [1:0] OP_MARK     = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Leaf kinds
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_SINGLE   = 2'd1;
  localparam logic [1:0] KIND_TEMPLATE = 2'd2;

  // Offset occupancy mask, bit (ox+1)*9 + (oy+1)*3 + (oz+1)
  typedef logic [NBH_W-1:0] nbh_t;

  typedef struct packed {
    logic             hit;
    logic [ROT_W-1:0] rot;
  } match_t;

  typedef struct packed {
    logic signed [2:0] x;
    logic signed [2:0] y;
    logic signed [2:0] z;
  } vec_t;

  localparam int SHAPE_SIZE [TEMPLATE_COUNT] = '{1, 1, 1, 2, 2, 2, 2, 3, 3};

  localparam int SHAPE_V [TEMPLATE_COUNT][TEMPLATE_MAX][3] = '{
    '{'{ 0,  0, -1}, '{ 0,  0,  0}, '{0,  0,  0}},
    '{'{ 0, -1, -1}, '{ 0,  0,  0}, '{0,  0,  0}},
    '{'{ 1, -1, -1}, '{ 0,  0,  0}, '{0,  0,  0}},
    '{'{ 0, -1, -1}, '{ 0,  0, -1}, '{0,  0,  0}},
    '{'{ 1, -1, -1}, '{ 0,  0, -1}, '{0,  0,  0}},
    '{'{-1, -1, -1}, '{-1,  0, -1}, '{0,  0,  0}},
    '{'{ 1, -1, -1}, '{ 1,  0, -1}, '{0,  0,  0}},
    '{'{ 0, -1, -1}, '{ 1, -1, -1}, '{0,  0, -1}},
    '{'{-1, -1, -1}, '{ 0, -1, -1}, '{0,  0, -1}}
  };

  // First axis, quarter turns, second axis, quarter turns
  localparam int TURN_PLAN [24][4] = '{
    '{0, 0, 0, 0}, '{2, 1, 0, 0}, '{2, 2, 0, 0}, '{2, 3, 0, 0},
    '{1, 1, 0, 0}, '{1, 1, 0, 1}, '{1, 1, 0, 2}, '{1, 1, 0, 3},
    '{1, 2, 0, 0}, '{1, 2, 2, 1}, '{1, 2, 2, 2}, '{1, 2, 2, 3},
    '{1, 3, 0, 0}, '{1, 3, 0, 1}, '{1, 3, 0, 2}, '{1, 3, 0, 3},
    '{0, 1, 0, 0}, '{0, 1, 1, 1}, '{0, 1, 1, 2}, '{0, 1, 1, 3},
    '{0, 3, 0, 0}, '{0, 3, 1, 1}, '{0, 3, 1, 2}, '{0, 3, 1, 3}
  };

  // One quarter turn about an axis
  function automatic vec_t qturn(input int axis, input vec_t p);
    vec_t q;
    q = p;
    if (axis == 0) begin
      q.y = -p.z;
      q.z = p.y;
    end else if (axis == 1) begin
      q.x = p.z;
      q.z = -p.x;
    end else begin
      q.x = -p.y;
      q.y = p.x;
    end
    return q;
  endfunction

  // Offset mask of a template under a rotation
  function automatic nbh_t tmpl_mask(input logic [TMPL_W-1:0] t, input int r);
    nbh_t m;
    vec_t p;
    int   ti;
    int   code;
    m  = '0;
    ti = int'(t);
    if (ti < TEMPLATE_COUNT) begin
      for (int i = 0; i < TEMPLATE_MAX; i++) begin
        if (i < SHAPE_SIZE[ti]) begin
          p.x = 3'(SHAPE_V[ti][i][0]);
          p.y = 3'(SHAPE_V[ti][i][1]);
          p.z = 3'(SHAPE_V[ti][i][2]);
          for (int k = 0; k < 3; k++)
            if (k < TURN_PLAN[r][1]) p = qturn(TURN_PLAN[r][0], p);
          for (int k = 0; k < 3; k++)
            if (k < TURN_PLAN[r][3]) p = qturn(TURN_PLAN[r][2], p);
          code = (int'(p.x) + 1) * 9 + (int'(p.y) + 1) * 3 + (int'(p.z) + 1);
          m[code] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

FILE: src/voxel_leaf_template_classifier_unit.sv
// Top level of the voxel leaf classifier: occupancy memory, sequencer and
// result register. Depends on vltc_pkg and vltc_match.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item:
//   op, x_coord, y_coord, z_coord. Output channel (out_valid/out_ready)
//   returns exactly one result transaction per input item.
//   Mark and clear read the z-column word, then write it back.
//   Classify reads the nine z-column words around the voxel in turn
//   through the single memory read port, then tries one template (all 24
//   rotations) per cycle. Unused op codes go straight to the result.
//   One item is in work at a time; the next is taken once the result
//   sits in the output register.
//   After reset the block sweeps the occupancy memory to empty, one column
//   word per cycle, with in_ready low.
//   When the receiver stalls, the result holds in the output register and
//   the block can finish at most one further item before it waits too.
module voxel_leaf_template_classifier_unit import vltc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [COORD_W-1:0] in_x_coord,
  input  logic [COORD_W-1:0] in_y_coord,
  input  logic [COORD_W-1:0] in_z_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_leaf_kind,
  output logic [CNT_W-1:0]   out_neighbour_count,
  output logic [TMPL_W-1:0]  out_template_index,
  output logic [ROT_W-1:0]   out_rotation_index
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MRD   = 3'd2;
  localparam logic [2:0] ST_MWR   = 3'd3;
  localparam logic [2:0] ST_CRD   = 3'd4;
  localparam logic [2:0] ST_MATCH = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam int CW1 = COORD_W + 1;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [3:0]          k_r, k_nxt;
  logic [1:0]          dxi_r, dxi_nxt, dyi_r, dyi_nxt;
  logic                pend_v_r, pend_v_nxt, pend_ok_r, pend_ok_nxt;
  logic [1:0]          pend_dx_r, pend_dx_nxt, pend_dy_r, pend_dy_nxt;
  nbh_t                nbh_r, nbh_nxt;
  logic [TMPL_W-1:0]   t_r, t_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TMPL_W-1:0]   tmpl_r, tmpl_nxt;
  logic [ROT_W-1:0]    rot_r, rot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [TMPL_W-1:0]   out_tmpl_r, out_tmpl_nxt;
  logic [ROT_W-1:0]    out_rot_r, out_rot_nxt;

  logic [GRID_Z-1:0]   mem [GRID_X * GRID_Y];
  logic [GRID_Z-1:0]   rd_data_r;
  logic [ADDR_W-1:0]   mem_raddr, mem_waddr, item_addr, nb_addr;
  logic [GRID_Z-1:0]   mem_wdata;
  logic                mem_we;

  logic [CW1-1:0]      nx, ny, zz;
  logic                nb_ok, item_ok;
  logic [CNT_W-1:0]    pop;
  match_t              match;
  logic                in_acc;

  vltc_match u_match (
    .tmpl   (t_r),
    .mask   (nbh_r),
    .result (match)
  );

  // Occupancy memory: one z-column word per (x, y)
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  // Address arithmetic
  always_comb begin
    nx = (CW1'(x_r) + CW1'(dxi_r)) - CW1'(1);
    ny = (CW1'(y_r) + CW1'(dyi_r)) - CW1'(1);
    nb_ok = (nx < CW1'(GRID_X)) && (ny < CW1'(GRID_Y));
    nb_addr = ADDR_W'(ADDR_W'(nx[COORD_W-1:0]) * ADDR_W'(GRID_Y))
            + ADDR_W'(ny[COORD_W-1:0]);
    item_addr = ADDR_W'(ADDR_W'(x_r) * ADDR_W'(GRID_Y)) + ADDR_W'(y_r);
    item_ok = (CW1'(x_r) < CW1'(GRID_X)) && (CW1'(y_r) < CW1'(GRID_Y))
           && (CW1'(z_r) < CW1'(GRID_Z));
    pop = '0;
    for (int i = 0; i < NBH_W; i++) pop = pop + CNT_W'(nbh_r[i]);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt = op_r; x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    k_nxt = k_r; dxi_nxt = dxi_r; dyi_nxt = dyi_r;
    pend_v_nxt = 1'b0; pend_ok_nxt = pend_ok_r;
    pend_dx_nxt = pend_dx_r; pend_dy_nxt = pend_dy_r;
    nbh_nxt = nbh_r; t_nxt = t_r;
    kind_nxt = kind_r; cnt_nxt = cnt_r; tmpl_nxt = tmpl_r; rot_nxt = rot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r; out_cnt_nxt = out_cnt_r;
    out_tmpl_nxt = out_tmpl_r; out_rot_nxt = out_rot_r;
    mem_raddr = item_addr;
    mem_waddr = item_addr;
    mem_wdata = rd_data_r;
    mem_we    = 1'b0;
    zz        = '0;

    case (state_r)
      ST_CLR: begin
        // Sweep the grid to empty
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        mem_we    = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(GRID_X * GRID_Y - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt = in_op; x_nxt = in_x_coord; y_nxt = in_y_coord;
          z_nxt = in_z_coord;
          kind_nxt = KIND_NONE; cnt_nxt = '0; tmpl_nxt = '0; rot_nxt = '0;
          k_nxt = '0; dxi_nxt = '0; dyi_nxt = '0;
          nbh_nxt = '0; t_nxt = '0;
          case (in_op)
            OP_MARK, OP_CLEAR: state_nxt = ST_MRD;
            OP_CLASSIFY:       state_nxt = ST_CRD;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MRD: begin
        // Read the column word of the item
        mem_raddr = item_addr;
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        // Set or drop the voxel bit and write back
        mem_wdata = rd_data_r;
        mem_wdata[z_r[ZIDX_W-1:0]] = (op_r == OP_MARK);
        mem_we    = item_ok;
        state_nxt = ST_DONE;
      end
      ST_CRD: begin
        // Issue the next neighbour column read
        mem_raddr = nb_addr;
        if (k_r < 4'd9) begin
          pend_v_nxt  = 1'b1;
          pend_ok_nxt = nb_ok;
          pend_dx_nxt = dxi_r;
          pend_dy_nxt = dyi_r;
          k_nxt = k_r + 4'd1;
          if (dyi_r == 2'd2) begin
            dyi_nxt = '0;
            dxi_nxt = dxi_r + 2'd1;
          end else begin
            dyi_nxt = dyi_r + 2'd1;
          end
        end
        // Fold the returned column into the offset mask
        if (pend_v_r) begin
          for (int c = 0; c < 3; c++) begin
            zz = (CW1'(z_r) + CW1'(c)) - CW1'(1);
            if (pend_ok_r && zz < CW1'(GRID_Z)
                && !(pend_dx_r == 2'd1 && pend_dy_r == 2'd1 && c == 1))
              nbh_nxt[(2 - int'(pend_dx_r)) * 9 + (2 - int'(pend_dy_r)) * 3
                      + (2 - c)] = rd_data_r[zz[ZIDX_W-1:0]];
          end
          if (k_r == 4'd9) state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        // One template per cycle, all rotations at once
        cnt_nxt = pop;
        if (pop == CNT_W'(1)) begin
          kind_nxt  = KIND_SINGLE;
          state_nxt = ST_DONE;
        end else if (match.hit) begin
          kind_nxt  = KIND_TEMPLATE;
          tmpl_nxt  = t_r;
          rot_nxt   = match.rot;
          state_nxt = ST_DONE;
        end else if (t_r == TMPL_W'(TEMPLATE_COUNT - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          t_nxt = t_r + TMPL_W'(1);
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_cnt_nxt   = cnt_r;
          out_tmpl_nxt  = tmpl_r;
          out_rot_nxt   = rot_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    k_r <= k_nxt; dxi_r <= dxi_nxt; dyi_r <= dyi_nxt;
    pend_ok_r <= pend_ok_nxt; pend_dx_r <= pend_dx_nxt; pend_dy_r <= pend_dy_nxt;
    nbh_r <= nbh_nxt; t_r <= t_nxt;
    kind_r <= kind_nxt; cnt_r <= cnt_nxt; tmpl_r <= tmpl_nxt; rot_r <= rot_nxt;
    out_kind_r <= out_kind_nxt; out_cnt_r <= out_cnt_nxt;
    out_tmpl_r <= out_tmpl_nxt; out_rot_r <= out_rot_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_leaf_kind       = out_kind_r;
  assign out_neighbour_count = out_cnt_r;
  assign out_template_index  = out_tmpl_r;
  assign out_rotation_index  = out_rot_r;

endmodule

FILE: src/vltc_match.sv
// Template matcher: compares an offset mask with all rotations of one
// template and returns the first matching rotation. Depends on vltc_pkg.
module vltc_match import vltc_pkg::*; (
  input  logic [TMPL_W-1:0] tmpl,
  input  nbh_t              mask,
  output match_t            result
);

  // Pick the lowest matching rotation
  always_comb begin
    result = '0;
    for (int r = ROTATION_COUNT - 1; r >= 0; r--) begin
      if (tmpl_mask(tmpl, r) == mask) begin
        result.hit = 1'b1;
        result.rot = ROT_W'(r);
      end
    end
  end

endmodule

FILE: src/vltc_checker.sv
// Port-level checks for the voxel leaf classifier and the bind that
// attaches them to the top level. Depends on vltc_pkg.
module vltc_checker import vltc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_leaf_kind,
  input logic [CNT_W-1:0]   out_neighbour_count,
  input logic [TMPL_W-1:0]  out_template_index,
  input logic [ROT_W-1:0]   out_rotation_index
);

  // Stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable(out_leaf_kind) && $stable(out_neighbour_count)
      && $stable(out_template_index) && $stable(out_rotation_index))
    else $error("stalled result changed");

  // Single neighbour leaf has one neighbour and no template
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leaf_kind == KIND_SINGLE |->
      out_neighbour_count == CNT_W'(1) && out_template_index == '0
      && out_rotation_index == '0)
    else $error("bad single leaf result");

  // Template match only for two or three neighbours, indices in range
  a_tmpl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leaf_kind == KIND_TEMPLATE |->
      (out_neighbour_count == CNT_W'(2) || out_neighbour_count == CNT_W'(3))
      && out_template_index >= TMPL_W'(3)
      && out_template_index < TMPL_W'(TEMPLATE_COUNT)
      && out_rotation_index < ROT_W'(ROTATION_COUNT))
    else $error("bad template result");

  // No leaf means no indices
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leaf_kind == KIND_NONE |->
      out_template_index == '0 && out_rotation_index == '0
      && out_neighbour_count != CNT_W'(1))
    else $error("bad non-leaf result");

endmodule

bind voxel_leaf_template_classifier_unit vltc_checker u_vltc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_leaf_kind       (out_leaf_kind),
  .out_neighbour_count (out_neighbour_count),
  .out_template_index  (out_template_index),
  .out_rotation_index  (out_rotation_index)
);

FILE: tb/voxel_leaf_template_classifier_unit_chk.sv
// Checker for the voxel leaf classifier: keeps its own occupancy grid, predicts
// one result per accepted input transaction and compares. Depends on vltc_pkg.
module voxel_leaf_template_classifier_unit_chk import vltc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [COORD_W-1:0] in_x_coord,
  input  logic [COORD_W-1:0] in_y_coord,
  input  logic [COORD_W-1:0] in_z_coord,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_leaf_kind,
  input  logic [CNT_W-1:0]   out_neighbour_count,
  input  logic [TMPL_W-1:0]  out_template_index,
  input  logic [ROT_W-1:0]   out_rotation_index,
  output int                 err_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [CNT_W-1:0]  cnt;
    logic [TMPL_W-1:0] tmpl;
    logic [ROT_W-1:0]  rot;
  } leaf_res_t;

  logic [GRID_Z-1:0] grid_cols [GRID_X*GRID_Y];
  leaf_res_t         leaf_q [$];
  int                shape_sz [9] = '{1, 1, 1, 2, 2, 2, 2, 3, 3};
  int                shape_v [9][3][3] = '{
    '{'{ 0,  0, -1}, '{ 0, 0,  0}, '{0, 0,  0}},
    '{'{ 0, -1, -1}, '{ 0, 0,  0}, '{0, 0,  0}},
    '{'{ 1, -1, -1}, '{ 0, 0,  0}, '{0, 0,  0}},
    '{'{ 0, -1, -1}, '{ 0, 0, -1}, '{0, 0,  0}},
    '{'{ 1, -1, -1}, '{ 0, 0, -1}, '{0, 0,  0}},
    '{'{-1, -1, -1}, '{-1, 0, -1}, '{0, 0,  0}},
    '{'{ 1, -1, -1}, '{ 1, 0, -1}, '{0, 0,  0}},
    '{'{ 0, -1, -1}, '{ 1, -1, -1}, '{0, 0, -1}},
    '{'{-1, -1, -1}, '{ 0, -1, -1}, '{0, 0, -1}}};
  int                plan [24][4] = '{
    '{0, 0, 0, 0}, '{2, 1, 0, 0}, '{2, 2, 0, 0}, '{2, 3, 0, 0},
    '{1, 1, 0, 0}, '{1, 1, 0, 1}, '{1, 1, 0, 2}, '{1, 1, 0, 3},
    '{1, 2, 0, 0}, '{1, 2, 2, 1}, '{1, 2, 2, 2}, '{1, 2, 2, 3},
    '{1, 3, 0, 0}, '{1, 3, 0, 1}, '{1, 3, 0, 2}, '{1, 3, 0, 3},
    '{0, 1, 0, 0}, '{0, 1, 1, 1}, '{0, 1, 1, 2}, '{0, 1, 1, 3},
    '{0, 3, 0, 0}, '{0, 3, 1, 1}, '{0, 3, 1, 2}, '{0, 3, 1, 3}};

  assign pending_count = leaf_q.size();

  function automatic logic occupied(int x, int y, int z);
    if (x < 0 || x >= GRID_X || y < 0 || y >= GRID_Y || z < 0 || z >= GRID_Z)
      return 1'b0;
    return grid_cols[x*GRID_Y + y][z];
  endfunction

  // Offset bit of one template vector after a rotation
  function automatic int turned_bit(int t, int i, int r);
    int p [3];
    int a;
    p = shape_v[t][i];
    for (int s = 0; s < 2; s++)
      for (int k = 0; k < plan[r][2*s+1]; k++) begin
        case (plan[r][2*s])
          0: begin a = p[1]; p[1] = -p[2]; p[2] = a; end
          1: begin a = p[0]; p[0] = p[2]; p[2] = -a; end
          default: begin a = p[0]; p[0] = -p[1]; p[1] = a; end
        endcase
      end
    return (p[0]+1)*9 + (p[1]+1)*3 + (p[2]+1);
  endfunction

  function automatic leaf_res_t classify_leaf(int x, int y, int z);
    leaf_res_t   res;
    logic [26:0] seen;
    logic [26:0] want;
    int          n;
    res  = '0;
    seen = '0;
    n    = 0;
    // gather offsets as voxel minus neighbour
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++)
          if (!(dx == 0 && dy == 0 && dz == 0) && occupied(x+dx, y+dy, z+dz)) begin
            seen[(1-dx)*9 + (1-dy)*3 + (1-dz)] = 1'b1;
            n++;
          end
    res.cnt = CNT_W'(n);
    if (n == 1) begin
      res.kind = KIND_SINGLE;
      return res;
    end
    for (int t = 0; t < 9; t++) begin
      if (shape_sz[t] != n) continue;
      for (int r = 0; r < 24; r++) begin
        want = '0;
        for (int i = 0; i < n; i++) want[turned_bit(t, i, r)] = 1'b1;
        if (want == seen) begin
          res.kind = KIND_TEMPLATE;
          res.tmpl = TMPL_W'(t);
          res.rot  = ROT_W'(r);
          return res;
        end
      end
    end
    return res;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    leaf_res_t exp_r;
    leaf_res_t got_r;
    int        x;
    int        y;
    int        z;
    if (!rst_n) begin
      foreach (grid_cols[i]) grid_cols[i] = '0;
      leaf_q.delete();
      err_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        x = in_x_coord;
        y = in_y_coord;
        z = in_z_coord;
        exp_r = '0;
        if (in_op == OP_MARK) grid_cols[x*GRID_Y + y][z] = 1'b1;
        else if (in_op == OP_CLEAR) grid_cols[x*GRID_Y + y][z] = 1'b0;
        else if (in_op == OP_CLASSIFY) exp_r = classify_leaf(x, y, z);
        leaf_q = {leaf_q, exp_r};
      end
      if (out_valid && out_ready) begin
        got_r = {out_leaf_kind, out_neighbour_count, out_template_index,
                 out_rotation_index};
        if (leaf_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result %h", got_r);
        end else begin
          exp_r = leaf_q.pop_front();
          if (got_r !== exp_r) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: exp kind %0d cnt %0d tmpl %0d rot %0d, got %0d %0d %0d %0d",
                       exp_r.kind, exp_r.cnt, exp_r.tmpl, exp_r.rot, got_r.kind,
                       got_r.cnt, got_r.tmpl, got_r.rot);
          end
        end
      end
    end
  end

endmodule

FILE: tb/voxel_leaf_template_classifier_unit_tb.sv
// Testbench top for the voxel leaf classifier: clock, reset, stimulus and
// verdict. Depends on vltc_pkg, the block and its checker.
module voxel_leaf_template_classifier_unit_tb import vltc_pkg::*; ();

  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic [COORD_W-1:0] in_x_coord;
  logic [COORD_W-1:0] in_y_coord;
  logic [COORD_W-1:0] in_z_coord;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_leaf_kind;
  logic [CNT_W-1:0]   out_neighbour_count;
  logic [TMPL_W-1:0]  out_template_index;
  logic [ROT_W-1:0]   out_rotation_index;
  int                 err_count;
  int                 pending_count;
  int                 idle_cycles;
  logic               quiet_mode;
  logic               hold_off;
  logic               feed_done;
  int                 base_x;
  int                 base_y;
  int                 base_z;

  voxel_leaf_template_classifier_unit u_dut (.*);

  voxel_leaf_template_classifier_unit_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Send one transaction and hold it until accepted
  task automatic send_voxel(logic [1:0] op, int x, int y, int z);
    while (!quiet_mode && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_x_coord <= COORD_W'(x);
    in_y_coord <= COORD_W'(y);
    in_z_coord <= COORD_W'(z);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Build a small cluster near a base voxel, then classify it
  task automatic leaf_cluster();
    int n;
    base_x = $urandom_range(63);
    base_y = $urandom_range(63);
    base_z = $urandom_range(63);
    if ($urandom_range(3) == 0) begin
      base_x = $urandom_range(1) * 63;
      base_z = $urandom_range(1) * 63;
    end
    n = $urandom_range(4);
    for (int i = 0; i < n; i++)
      send_voxel(OP_MARK, (base_x + $urandom_range(2) + 63) % 64,
                 (base_y + $urandom_range(2) + 63) % 64,
                 (base_z + $urandom_range(2) + 63) % 64);
    send_voxel(OP_CLASSIFY, base_x, base_y, base_z);
    // tidy up the neighbourhood so clusters stay sparse
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++)
          if ($urandom_range(3) != 0)
            send_voxel(OP_CLEAR, (base_x + dx + 64) % 64, (base_y + dy + 64) % 64,
                       (base_z + dz + 64) % 64);
  endtask

  // Receiver: random stalls unless in quiet mode, plus one long timed hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && (quiet_mode || $urandom_range(99) >= 23);
  end

  initial begin
    hold_off = 1'b0;
    wait (feed_done === 1'b0);
    repeat (6000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("voxel_leaf_template_classifier_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_MARK;
    in_x_coord = '0;
    in_y_coord = '0;
    in_z_coord = '0;
    quiet_mode = 1'b0;
    feed_done  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: corners, unused op code, single and template leaves
    send_voxel(OP_CLASSIFY, 0, 0, 0);
    send_voxel(OP_MARK, 63, 63, 63);
    send_voxel(OP_CLASSIFY, 62, 62, 62);
    send_voxel(OP_CLASSIFY, 63, 63, 63);
    send_voxel(2'd3, 63, 0, 63);
    send_voxel(OP_MARK, 10, 10, 9);
    send_voxel(OP_CLASSIFY, 10, 10, 10);
    send_voxel(OP_MARK, 10, 11, 11);
    send_voxel(OP_CLASSIFY, 10, 10, 10);
    send_voxel(OP_MARK, 9, 11, 11);
    send_voxel(OP_CLASSIFY, 10, 10, 10);
    send_voxel(OP_MARK, 11, 9, 11);
    send_voxel(OP_CLASSIFY, 10, 10, 10);
    send_voxel(OP_CLASSIFY, 20, 20, 20);
    send_voxel(OP_CLEAR, 63, 63, 63);
    send_voxel(OP_CLASSIFY, 62, 62, 62);
    send_voxel(OP_MARK, 0, 0, 1);
    send_voxel(OP_MARK, 1, 1, 0);
    send_voxel(OP_CLASSIFY, 0, 0, 0);
    // random: mostly clusters, some noise
    for (int k = 0; k < 60; k++) begin
      quiet_mode = (k >= 40 && k < 55);
      if ($urandom_range(4) == 0)
        send_voxel(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                   $urandom_range(63));
      else leaf_cluster();
    end
    in_valid  <= 1'b0;
    feed_done = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("voxel_leaf_template_classifier_unit_tb: done, clean");
    else $display("voxel_leaf_template_classifier_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/vltc_pkg.sv
src/vltc_match.sv
src/voxel_leaf_template_classifier_unit.sv
src/vltc_checker.sv
tb/voxel_leaf_template_classifier_unit_chk.sv
tb/voxel_leaf_template_classifier_unit_tb.sv
